FILE: design/gpmg_pkg.sv
// ----------------------------------------------------------------------------
// gpmg_pkg
// Shared constants, types and codes of the greedy particle matcher.
// ----------------------------------------------------------------------------
package gpmg_pkg;

   localparam int PARTICLES = 512;
   localparam int IDX_W     = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
   localparam int CNT_W     = $clog2(PARTICLES + 1);

   localparam int SEL_W     = 9;
   localparam int POS_W     = 18;
   localparam int PROG_W    = 17;
   localparam int FRAMES_W  = 7;
   localparam int KIND_W    = 3;
   localparam int CSR_IDX_W = 2;

   localparam logic [PROG_W-1:0]   ONE_Q16      = 17'h10000;
   localparam logic [POS_W-1:0]    EASE_K       = 18'd196608;
   localparam logic [FRAMES_W-1:0] FRAMES_RESET = 7'd40;

   typedef logic signed [POS_W-1:0] pos_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_LOAD   = 3'd0,
      KIND_BEGIN  = 3'd1,
      KIND_TARGET = 3'd2,
      KIND_FINISH = 3'd3,
      KIND_TICK   = 3'd4,
      KIND_READ   = 3'd5
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CENTER_X     = 2'd0,
      CSR_CENTER_Y     = 2'd1,
      CSR_MORPH_FRAMES = 2'd2
   } csr_idx_type;

   typedef enum logic [2:0] {
      OP_CLEAR,
      OP_LOAD,
      OP_BEGIN,
      OP_SCAN,
      OP_FINISH,
      OP_TICK,
      OP_READ,
      OP_CLAIM
   } op_type;

   typedef struct packed {
      pos_type cur_x;
      pos_type cur_y;
      pos_type org_x;
      pos_type org_y;
      pos_type goal_x;
      pos_type goal_y;
      logic    claimed;
      logic    active;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [3:0] {
      ST_CLEAR_GO,
      ST_CLEAR_RUN,
      ST_IDLE,
      ST_EXEC,
      ST_DIV,
      ST_STEP,
      ST_EASE1,
      ST_EASE2,
      ST_RUN,
      ST_CLAIM,
      ST_CLAIM_RUN,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic   latch;
      logic   eng_start;
      logic   single;
      op_type op;
      logic   div_start;
      logic   prog_step;
      logic   prog_zero;
      logic   out_load;
   } cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              sel_ok;
      logic              busy;
      logic              div_busy;
      logic              prog_done;
      logic              found;
      logic              out_full;
   } stat_type;

endpackage

FILE: design/gpmg_if.sv
// ----------------------------------------------------------------------------
// gpmg_if
// Valid/ready channels of the matcher: request, response and register write.
// ----------------------------------------------------------------------------
interface gpmg_req_if;
   logic                         valid;
   logic                         ready;
   logic [gpmg_pkg::KIND_W-1:0]  kind;
   logic [gpmg_pkg::SEL_W-1:0]   particle_sel;
   gpmg_pkg::pos_type            x_pos;
   gpmg_pkg::pos_type            y_pos;

   modport source (output valid, kind, particle_sel, x_pos, y_pos, input ready);
   modport sink   (input valid, kind, particle_sel, x_pos, y_pos, output ready);
endinterface

interface gpmg_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [gpmg_pkg::SEL_W-1:0]   particle_index;
   logic                         found;
   gpmg_pkg::pos_type            pos_x;
   gpmg_pkg::pos_type            pos_y;
   logic                         is_active;
   logic [gpmg_pkg::PROG_W-1:0]  progress;
   logic                         morph_done;

   modport source (output valid, particle_index, found, pos_x, pos_y, is_active,
                   progress, morph_done, input ready);
   modport sink   (input valid, particle_index, found, pos_x, pos_y, is_active,
                   progress, morph_done, output ready);
endinterface

interface gpmg_csr_if;
   logic                           valid;
   logic                           ready;
   logic [gpmg_pkg::CSR_IDX_W-1:0] index;
   logic [gpmg_pkg::POS_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/greedy_point_match_glide.sv
// ----------------------------------------------------------------------------
// greedy_point_match_glide
// Greedy nearest-particle matcher with smoothstep glide of 512 particles.
// ----------------------------------------------------------------------------
//   channel   dir   handshake      contents
//   req_bus   in    valid/ready    kind, particle_sel, x_pos, y_pos
//   rsp_bus   out   valid/ready    particle_index, found, pos_x, pos_y,
//                                  is_active, progress, morph_done
//   csr_bus   in    valid/ready    index, data (ready always high)
//
// One transaction at a time. Target point, begin, finish and tick sweep the
// dual-port particle RAM one entry per cycle (tick only while the glide is
// unfinished, after the step divider and easing; target then claims a hit).
// Load and read touch only the selected entry. After reset a clearing pass
// over the whole RAM runs before the first request is taken.
// A stalled response holds the block in its last step until taken.
// ----------------------------------------------------------------------------
module greedy_point_match_glide (
   input  logic        clock,
   input  logic        reset,
   gpmg_req_if.sink    req_bus,
   gpmg_rsp_if.source  rsp_bus,
   gpmg_csr_if.sink    csr_bus
);
   import gpmg_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   logic     req_ready;

   assign req_bus.ready = req_ready;

   gpmg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   gpmg_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_kind (req_bus.kind),
      .req_sel  (req_bus.particle_sel),
      .req_x    (req_bus.x_pos),
      .req_y    (req_bus.y_pos),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_bus  (rsp_bus),
      .csr_bus  (csr_bus)
   );

endmodule

FILE: design/gpmg_ram.sv
// ----------------------------------------------------------------------------
// gpmg_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gpmg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/gpmg_ctrl.sv
// ----------------------------------------------------------------------------
// gpmg_ctrl
// Sequencer: dispatches each transaction to the sweep engine, divider and
// easing stages, then hands the result to the response register.
// ----------------------------------------------------------------------------
module gpmg_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  gpmg_pkg::stat_type stat,
   output gpmg_pkg::cmd_type  cmd
);
   import gpmg_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR_GO;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR_GO:  state_in = ST_CLEAR_RUN;
         ST_CLEAR_RUN: if (!stat.busy) state_in = ST_IDLE;
         ST_IDLE:      if (req_valid) state_in = ST_EXEC;
         ST_EXEC: begin
            case (stat.kind) inside
               KIND_LOAD, KIND_READ: state_in = stat.sel_ok ? ST_RUN : ST_RESP;
               KIND_BEGIN, KIND_TARGET, KIND_FINISH: state_in = ST_RUN;
               KIND_TICK:  state_in = stat.prog_done ? ST_RESP : ST_DIV;
               default:    state_in = ST_RESP;
            endcase
         end
         ST_DIV:       if (!stat.div_busy) state_in = ST_STEP;
         ST_STEP:      state_in = ST_EASE1;
         ST_EASE1:     state_in = ST_EASE2;
         ST_EASE2:     state_in = ST_RUN;
         ST_RUN: begin
            if (!stat.busy) begin
               state_in = (stat.kind == KIND_TARGET && stat.found) ? ST_CLAIM : ST_RESP;
            end
         end
         ST_CLAIM:     state_in = ST_CLAIM_RUN;
         ST_CLAIM_RUN: if (!stat.busy) state_in = ST_RESP;
         ST_RESP:      if (!stat.out_full) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      cmd.op    = OP_CLEAR;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR_GO: begin
            cmd.eng_start = 1'b1;
            cmd.op        = OP_CLEAR;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.latch = req_valid;
         end
         ST_EXEC: begin
            case (stat.kind)
               KIND_LOAD: begin
                  cmd.eng_start = stat.sel_ok;
                  cmd.single    = 1'b1;
                  cmd.op        = OP_LOAD;
               end
               KIND_READ: begin
                  cmd.eng_start = stat.sel_ok;
                  cmd.single    = 1'b1;
                  cmd.op        = OP_READ;
               end
               KIND_BEGIN: begin
                  cmd.eng_start = 1'b1;
                  cmd.op        = OP_BEGIN;
               end
               KIND_TARGET: begin
                  cmd.eng_start = 1'b1;
                  cmd.op        = OP_SCAN;
               end
               KIND_FINISH: begin
                  cmd.eng_start = 1'b1;
                  cmd.op        = OP_FINISH;
                  cmd.prog_zero = 1'b1;
               end
               KIND_TICK: cmd.div_start = !stat.prog_done;
               default: ;
            endcase
         end
         ST_STEP: cmd.prog_step = 1'b1;
         ST_EASE2: begin
            cmd.eng_start = 1'b1;
            cmd.op        = OP_TICK;
         end
         ST_CLAIM: begin
            cmd.eng_start = 1'b1;
            cmd.single    = 1'b1;
            cmd.op        = OP_CLAIM;
         end
         ST_RESP: cmd.out_load = !stat.out_full;
         default: ;
      endcase
   end

endmodule

FILE: design/gpmg_dp.sv
// ----------------------------------------------------------------------------
// gpmg_dp
// Datapath: particle RAM with a two-stage read/modify/write sweep engine,
// nearest-point search, step divider, smoothstep stages and result register.
// ----------------------------------------------------------------------------
module gpmg_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [gpmg_pkg::KIND_W-1:0]       req_kind,
   input  logic [gpmg_pkg::SEL_W-1:0]        req_sel,
   input  gpmg_pkg::pos_type                 req_x,
   input  gpmg_pkg::pos_type                 req_y,
   input  gpmg_pkg::cmd_type                 cmd,
   output gpmg_pkg::stat_type                stat,
   gpmg_rsp_if.source                        rsp_bus,
   gpmg_csr_if.sink                          csr_bus
);
   import gpmg_pkg::*;

   // latched transaction
   logic [KIND_W-1:0] kind_ff;
   logic [SEL_W-1:0]  sel_ff;
   pos_type           xp_ff, yp_ff;
   logic              sel_ok;

   // configuration
   pos_type             center_x_ff, center_y_ff;
   logic [FRAMES_W-1:0] frames_ff;

   // sweep engine
   op_type             op_ff;
   logic               act_ff;
   logic [IDX_W-1:0]   addr_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [IDX_W-1:0]   base_addr;
   logic               s1_valid_ff, s2_valid_ff;
   logic [IDX_W-1:0]   s1_idx_ff, s2_idx_ff;
   logic [ENTRY_W-1:0] ram_rd_data;
   entry_type          rd_word, word_s1, s2_word_ff, wr_word;
   logic               wr_en;
   logic               busy;

   // tick arithmetic
   logic signed [18:0] dgx, dgy;
   logic signed [17:0] s_sgn;
   logic signed [36:0] prod_x_in, prod_y_in, prod_x_ff, prod_y_ff;
   logic signed [36:0] sum_x, sum_y;

   // search arithmetic
   logic signed [18:0] dx, dy;
   logic signed [37:0] sqx_in, sqy_in;
   logic [37:0]        sqx_ff, sqy_ff;
   logic [38:0]        d2;
   logic               have_ff;
   logic [38:0]        best_d_ff;
   logic [IDX_W-1:0]   best_ff;

   // read capture
   pos_type rd_px_ff, rd_py_ff;
   logic    rd_act_ff;

   // progress, divider, easing
   logic [PROG_W-1:0]   prog_ff;
   logic [PROG_W:0]     prog_sum;
   logic [PROG_W-1:0]   step;
   logic                div_busy_ff;
   logic [4:0]          div_cnt_ff;
   logic [FRAMES_W-1:0] rem_ff;
   logic [PROG_W-1:0]   quo_ff;
   logic [FRAMES_W:0]   div_r;
   logic                div_ge;
   logic [33:0]         pp_ff;
   logic [POS_W-1:0]    ease_k;
   logic [51:0]         ease_prod;
   logic [PROG_W-1:0]   s_ff;

   // response register
   logic              out_valid_ff;
   logic [SEL_W-1:0]  out_idx_ff;
   logic              out_found_ff;
   pos_type           out_px_ff, out_py_ff;
   logic              out_act_ff;
   logic [PROG_W-1:0] out_prog_ff;
   logic              out_done_ff;

   // ---------------------------------------------------------------- request
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         kind_ff <= req_kind;
         sel_ff  <= req_sel;
         xp_ff   <= req_x;
         yp_ff   <= req_y;
      end
   end

   assign sel_ok = (32'(sel_ff) < 32'(PARTICLES));

   // ---------------------------------------------------------------- config
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         frames_ff   <= FRAMES_RESET;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_CENTER_X:     center_x_ff <= csr_bus.data;
            CSR_CENTER_Y:     center_y_ff <= csr_bus.data;
            CSR_MORPH_FRAMES: frames_ff   <= csr_bus.data[FRAMES_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- engine
   always_comb begin
      base_addr = '0;
      if (cmd.single) begin
         base_addr = (cmd.op == OP_CLAIM) ? best_ff : IDX_W'(sel_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff      <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= act_ff;
         s2_valid_ff <= s1_valid_ff;
         if (cmd.eng_start) begin
            act_ff <= 1'b1;
         end else if (act_ff && cnt_ff == CNT_W'(1)) begin
            act_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_idx_ff <= addr_ff;
      s2_idx_ff <= s1_idx_ff;
      if (cmd.eng_start) begin
         op_ff   <= cmd.op;
         addr_ff <= base_addr;
         cnt_ff  <= cmd.single ? CNT_W'(1) : CNT_W'(PARTICLES);
      end else if (act_ff) begin
         addr_ff <= addr_ff + IDX_W'(1);
         cnt_ff  <= cnt_ff - CNT_W'(1);
      end
   end

   assign busy = act_ff | s1_valid_ff | s2_valid_ff;

   gpmg_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (PARTICLES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s2_idx_ff),
      .wr_data (wr_word),
      .rd_addr (addr_ff),
      .rd_data (ram_rd_data)
   );

   assign rd_word = ram_rd_data;

   // stage 1: modify the entry read back
   always_comb begin
      word_s1 = rd_word;
      unique case (op_ff) inside
         OP_CLEAR: word_s1 = '0;
         OP_LOAD: begin
            word_s1.cur_x = xp_ff;
            word_s1.cur_y = yp_ff;
         end
         OP_BEGIN: begin
            word_s1.claimed = 1'b0;
            word_s1.active  = 1'b0;
         end
         OP_FINISH: begin
            if (!rd_word.claimed) begin
               word_s1.active = 1'b0;
               word_s1.goal_x = center_x_ff;
               word_s1.goal_y = center_y_ff;
            end
            word_s1.org_x = rd_word.cur_x;
            word_s1.org_y = rd_word.cur_y;
         end
         OP_CLAIM: begin
            word_s1.claimed = 1'b1;
            word_s1.active  = 1'b1;
            word_s1.goal_x  = xp_ff;
            word_s1.goal_y  = yp_ff;
         end
         OP_SCAN, OP_TICK, OP_READ: ;
         default: ;
      endcase
   end

   assign dgx       = 19'(rd_word.goal_x) - 19'(rd_word.org_x);
   assign dgy       = 19'(rd_word.goal_y) - 19'(rd_word.org_y);
   assign s_sgn     = $signed({1'b0, s_ff});
   assign prod_x_in = s_sgn * dgx;
   assign prod_y_in = s_sgn * dgy;

   assign dx     = 19'(rd_word.cur_x) - 19'(xp_ff);
   assign dy     = 19'(rd_word.cur_y) - 19'(yp_ff);
   assign sqx_in = dx * dx;
   assign sqy_in = dy * dy;

   always_ff @(posedge clock) begin
      s2_word_ff <= word_s1;
      prod_x_ff  <= prod_x_in;
      prod_y_ff  <= prod_y_in;
      sqx_ff     <= sqx_in;
      sqy_ff     <= sqy_in;
      if (cmd.latch) begin
         rd_px_ff  <= '0;
         rd_py_ff  <= '0;
         rd_act_ff <= 1'b0;
      end else if (s1_valid_ff && op_ff == OP_READ) begin
         rd_px_ff  <= rd_word.cur_x;
         rd_py_ff  <= rd_word.cur_y;
         rd_act_ff <= rd_word.active;
      end
   end

   // stage 2: finish the glide and write back
   assign sum_x = 37'(s2_word_ff.org_x) + (prod_x_ff >>> 16);
   assign sum_y = 37'(s2_word_ff.org_y) + (prod_y_ff >>> 16);

   always_comb begin
      wr_word = s2_word_ff;
      if (op_ff == OP_TICK) begin
         wr_word.cur_x = sum_x[POS_W-1:0];
         wr_word.cur_y = sum_y[POS_W-1:0];
      end
   end

   assign wr_en = s2_valid_ff && op_ff != OP_SCAN && op_ff != OP_READ;

   // stage 2: keep the nearest unclaimed particle, first index on ties
   assign d2 = 39'(sqx_ff) + 39'(sqy_ff);

   always_ff @(posedge clock) begin
      if (cmd.eng_start && cmd.op == OP_SCAN) begin
         have_ff <= 1'b0;
      end else if (s2_valid_ff && op_ff == OP_SCAN && !s2_word_ff.claimed) begin
         if (!have_ff || d2 < best_d_ff) begin
            have_ff   <= 1'b1;
            best_d_ff <= d2;
            best_ff   <= s2_idx_ff;
         end
      end
   end

   // ---------------------------------------------------------------- glide
   // restoring divide of 65536 by the frame count, one quotient bit a cycle
   assign div_r  = {rem_ff, div_cnt_ff == 5'd16};
   assign div_ge = (div_r >= {1'b0, frames_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
      end else if (cmd.div_start) begin
         div_busy_ff <= 1'b1;
      end else if (div_busy_ff && div_cnt_ff == 5'd0) begin
         div_busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         div_cnt_ff <= 5'd16;
         rem_ff     <= '0;
         quo_ff     <= '0;
      end else if (div_busy_ff) begin
         div_cnt_ff <= div_cnt_ff - 5'd1;
         rem_ff     <= div_ge ? FRAMES_W'(div_r - {1'b0, frames_ff}) : div_r[FRAMES_W-1:0];
         quo_ff     <= {quo_ff[PROG_W-2:0], div_ge};
      end
   end

   assign step     = (frames_ff == '0) ? ONE_Q16 : quo_ff;
   assign prog_sum = {1'b0, prog_ff} + {1'b0, step};

   always_ff @(posedge clock) begin
      if (reset) begin
         prog_ff <= ONE_Q16;
      end else if (cmd.prog_zero) begin
         prog_ff <= '0;
      end else if (cmd.prog_step) begin
         prog_ff <= (prog_sum > {1'b0, ONE_Q16}) ? ONE_Q16 : prog_sum[PROG_W-1:0];
      end
   end

   // smoothstep: s = p*p*(3*65536 - 2p) / 2^32, two registered products
   assign ease_k    = EASE_K - {prog_ff, 1'b0};
   assign ease_prod = pp_ff * ease_k;

   always_ff @(posedge clock) begin
      pp_ff <= prog_ff * prog_ff;
      s_ff  <= ease_prod[48:32];
   end

   // ---------------------------------------------------------------- response
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_found_ff <= (kind_ff == KIND_TARGET) && have_ff;
         if (kind_ff == KIND_READ) begin
            out_idx_ff <= sel_ff;
         end else if (kind_ff == KIND_TARGET && have_ff) begin
            out_idx_ff <= SEL_W'(best_ff);
         end else begin
            out_idx_ff <= '0;
         end
         out_px_ff   <= rd_px_ff;
         out_py_ff   <= rd_py_ff;
         out_act_ff  <= rd_act_ff;
         out_prog_ff <= prog_ff;
         out_done_ff <= (prog_ff == ONE_Q16);
      end
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.particle_index = out_idx_ff;
   assign rsp_bus.found          = out_found_ff;
   assign rsp_bus.pos_x          = out_px_ff;
   assign rsp_bus.pos_y          = out_py_ff;
   assign rsp_bus.is_active      = out_act_ff;
   assign rsp_bus.progress       = out_prog_ff;
   assign rsp_bus.morph_done     = out_done_ff;

   // ---------------------------------------------------------------- status
   always_comb begin
      stat           = '0;
      stat.kind      = kind_ff;
      stat.sel_ok    = sel_ok;
      stat.busy      = busy;
      stat.div_busy  = div_busy_ff;
      stat.prog_done = (prog_ff == ONE_Q16);
      stat.found     = have_ff;
      stat.out_full  = out_valid_ff;
   end

   // ---------------------------------------------------------------- checks
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.eng_start |-> !busy)
      else $error("sweep started while engine busy");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !div_busy_ff)
      else $error("divider restarted while busy");

   a_prog_range: assert property (@(posedge clock) disable iff (reset)
      prog_ff <= ONE_Q16)
      else $error("progress above one");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !out_valid_ff && !busy)
      else $error("response loaded over a pending one or during a sweep");

endmodule

FILE: sim/greedy_point_match_glide_tb.sv
// ----------------------------------------------------------------------------
// greedy_point_match_glide_tb
// Self-checking bench for the greedy particle matcher with eased glide.
// A behavioral predictor tracks every particle, the claim marks, the progress
// and the registers. Each accepted request pushes its expected response,
// and the response monitor compares them field by field, in order.
// ----------------------------------------------------------------------------
module greedy_point_match_glide_tb;
   import gpmg_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 20000;

   // kind codes with no operation behind them
   localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
   localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;

   typedef struct {
      logic [SEL_W-1:0]  particle_index;
      logic              found;
      pos_type           pos_x;
      pos_type           pos_y;
      logic              is_active;
      logic [PROG_W-1:0] progress;
      logic              morph_done;
   } match_rsp_type;

   logic clock;
   logic reset;

   gpmg_req_if req_bus ();
   gpmg_rsp_if rsp_bus ();
   gpmg_csr_if csr_bus ();

   greedy_point_match_glide u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // particle mirror and register copy
   pos_type           cur_x  [PARTICLES];
   pos_type           cur_y  [PARTICLES];
   pos_type           org_x  [PARTICLES];
   pos_type           org_y  [PARTICLES];
   pos_type           goal_x [PARTICLES];
   pos_type           goal_y [PARTICLES];
   bit                active [PARTICLES];
   bit                claimed[PARTICLES];
   logic [PROG_W-1:0] glide_prog;
   pos_type           park_x;
   pos_type           park_y;
   logic [FRAMES_W-1:0] frames;

   match_rsp_type pending_rsp[$];
   int         mismatches;
   int         items_sent;
   int         claims_seen;
   int         ticks_sent;
   int         send_idle_pct;
   int         rsp_stall_pct;
   int         idle_cycles;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic logic [PROG_W-1:0] ease(logic [PROG_W-1:0] p);
      longint unsigned pl;
      longint unsigned pp;
      longint unsigned k;
      pl = p;
      pp = pl * pl;
      k  = 64'd196608 - 2 * pl;
      return PROG_W'((pp * k) >> 32);
   endfunction

   function automatic pos_type glide_to(pos_type from_p, pos_type to_p,
                                        logic [PROG_W-1:0] s);
      longint prod;
      prod = longint'(s) * (longint'(to_p) - longint'(from_p));
      return pos_type'(longint'(from_p) + (prod >>> 16));
   endfunction

   // apply one request to the mirror and return the response it causes
   function automatic match_rsp_type predict_match(logic [KIND_W-1:0] kind,
                                                   logic [SEL_W-1:0] sel,
                                                   pos_type xp, pos_type yp);
      match_rsp_type r;
      bit         have;
      longint     best;
      longint     dx;
      longint     dy;
      longint     d2;
      int         best_i;
      logic [PROG_W-1:0] s;
      int unsigned step;
      r = '{default: '0};
      have = 0;
      best = 0;
      best_i = 0;
      case (kind)
         KIND_LOAD: begin
            cur_x[sel] = xp;
            cur_y[sel] = yp;
         end
         KIND_BEGIN: begin
            for (int i = 0; i < PARTICLES; i++) begin
               active[i]  = 0;
               claimed[i] = 0;
            end
         end
         KIND_TARGET: begin
            for (int i = 0; i < PARTICLES; i++) begin
               if (!claimed[i]) begin
                  dx = longint'(cur_x[i]) - longint'(xp);
                  dy = longint'(cur_y[i]) - longint'(yp);
                  d2 = dx * dx + dy * dy;
                  if (!have || d2 < best) begin
                     have = 1;
                     best = d2;
                     best_i = i;
                  end
               end
            end
            if (have) begin
               claimed[best_i] = 1;
               active[best_i]  = 1;
               goal_x[best_i]  = xp;
               goal_y[best_i]  = yp;
               r.found = 1'b1;
               r.particle_index = SEL_W'(best_i);
            end
         end
         KIND_FINISH: begin
            for (int i = 0; i < PARTICLES; i++) begin
               if (!claimed[i]) begin
                  active[i] = 0;
                  goal_x[i] = park_x;
                  goal_y[i] = park_y;
               end
               org_x[i] = cur_x[i];
               org_y[i] = cur_y[i];
            end
            glide_prog = '0;
         end
         KIND_TICK: begin
            if (glide_prog < ONE_Q16) begin
               step = (frames == 0) ? 65536 : 65536 / frames;
               if (int'(glide_prog) + step > 65536) glide_prog = ONE_Q16;
               else glide_prog = PROG_W'(int'(glide_prog) + step);
               s = ease(glide_prog);
               for (int i = 0; i < PARTICLES; i++) begin
                  cur_x[i] = glide_to(org_x[i], goal_x[i], s);
                  cur_y[i] = glide_to(org_y[i], goal_y[i], s);
               end
            end
         end
         KIND_READ: begin
            r.particle_index = sel;
            r.pos_x = cur_x[sel];
            r.pos_y = cur_y[sel];
            r.is_active = active[sel];
         end
         default: ;
      endcase
      r.progress   = glide_prog;
      r.morph_done = (glide_prog >= ONE_Q16);
      return r;
   endfunction

   // send one request; entered and left at a rising edge
   task automatic send_item(logic [KIND_W-1:0] kind, logic [SEL_W-1:0] sel,
                            pos_type xp, pos_type yp);
      match_rsp_type r;
      while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      req_bus.valid        <= 1'b1;
      req_bus.kind         <= kind;
      req_bus.particle_sel <= sel;
      req_bus.x_pos        <= xp;
      req_bus.y_pos        <= yp;
      do @(posedge clock); while (!req_bus.ready);
      r = predict_match(kind, sel, xp, yp);
      pending_rsp.push_back(r);
      items_sent++;
      if (kind == KIND_TICK) ticks_sent++;
      req_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(csr_idx_type idx, logic [POS_W-1:0] value);
      wait_drained();
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         CSR_CENTER_X:     park_x = pos_type'(value);
         CSR_CENTER_Y:     park_y = pos_type'(value);
         CSR_MORPH_FRAMES: frames = value[FRAMES_W-1:0];
         default: ;
      endcase
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic pos_type rand_pos();
      case ($urandom_range(5))
         0:       return pos_type'(18'h20000);
         1:       return pos_type'(18'h1FFFF);
         2:       return pos_type'($urandom_range(255)) - 128;
         default: return pos_type'($urandom);
      endcase
   endfunction

   // compare each response with the oldest expectation
   always @(posedge clock) begin
      match_rsp_type e;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response at %0t", $realtime);
         end else begin
            e = pending_rsp.pop_front();
            if (e.found) claims_seen++;
            if (rsp_bus.particle_index !== e.particle_index || rsp_bus.found !== e.found ||
                rsp_bus.pos_x !== e.pos_x || rsp_bus.pos_y !== e.pos_y ||
                rsp_bus.is_active !== e.is_active || rsp_bus.progress !== e.progress ||
                rsp_bus.morph_done !== e.morph_done) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch at %0t: exp idx %0d fnd %0d x %0d y %0d act %0d %s",
                           $realtime, e.particle_index, e.found, e.pos_x, e.pos_y,
                           e.is_active, $sformatf("prog %0d done %0d", e.progress,
                                                  e.morph_done));
                  $display("   got idx %0d fnd %0d x %0d y %0d act %0d prog %0d done %0d",
                           rsp_bus.particle_index, rsp_bus.found, rsp_bus.pos_x,
                           rsp_bus.pos_y, rsp_bus.is_active, rsp_bus.progress,
                           rsp_bus.morph_done);
               end
            end
         end
      end
      rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // every particle needs a position before any scan or read
   task automatic test_load_all();
      for (int i = 0; i < PARTICLES; i++) begin
         send_item(KIND_LOAD, SEL_W'(i), rand_pos(), rand_pos());
      end
   endtask

   task automatic test_directed();
      pos_type p;
      csr_write(CSR_CENTER_X, 18'h20000);
      csr_write(CSR_CENTER_Y, 18'h1FFFF);
      p = pos_type'(18'h00440);
      // equal distance: lower index must win
      send_item(KIND_LOAD, 9'd3, p, p);
      send_item(KIND_LOAD, 9'd7, p, p);
      send_item(KIND_LOAD, 9'd511, pos_type'(18'h20000), pos_type'(18'h1FFFF));
      send_item(KIND_BEGIN, '0, '0, '0);
      send_item(KIND_TARGET, '0, p, p);
      send_item(KIND_TARGET, '0, p, p);
      send_item(KIND_TARGET, '0, pos_type'(18'h20000), pos_type'(18'h1FFFF));
      send_item(KIND_TARGET, '0, pos_type'(18'h1FFFF), pos_type'(18'h20000));
      send_item(KIND_FINISH, '0, '0, '0);
      send_item(KIND_READ, 9'd511, '0, '0);
      send_item(KIND_SPARE_A, 9'h1FF, pos_type'(18'h3FFFF), pos_type'(18'h3FFFF));
      send_item(KIND_SPARE_B, '0, '0, '0);
      send_item(KIND_TICK, '0, '0, '0);
      send_item(KIND_READ, 9'd3, '0, '0);
      csr_write(CSR_MORPH_FRAMES, 18'd0);
      // zero frames: glide completes in one tick, then ticks do nothing
      send_item(KIND_TICK, '0, '0, '0);
      send_item(KIND_TICK, '0, '0, '0);
      send_item(KIND_READ, 9'd0, '0, '0);
      send_item(KIND_READ, 9'd7, '0, '0);
      send_item(KIND_READ, 9'd511, '0, '0);
   endtask

   // claim every particle, then ask once more with nothing left
   task automatic test_exhaust();
      csr_write(CSR_MORPH_FRAMES, 18'd127);
      send_item(KIND_BEGIN, '0, '0, '0);
      for (int i = 0; i <= PARTICLES; i++) send_item(KIND_TARGET, '0, rand_pos(), rand_pos());
      send_item(KIND_FINISH, '0, '0, '0);
      for (int i = 0; i < 4; i++) send_item(KIND_TICK, '0, '0, '0);
      send_item(KIND_READ, 9'($urandom), '0, '0);
   endtask

   task automatic test_random(int n_items, int idle_pct, int stall_pct);
      int stop_at;
      int n;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      stop_at = items_sent + n_items;
      while (items_sent < stop_at) begin
         case ($urandom_range(3))
            0: csr_write(CSR_CENTER_X, POS_W'($urandom));
            1: csr_write(CSR_CENTER_Y, POS_W'($urandom));
            2: csr_write(CSR_MORPH_FRAMES, ($urandom_range(3) == 0) ?
                         POS_W'(FRAMES_W'($urandom)) : POS_W'($urandom_range(10, 20)));
            default: ;
         endcase
         n = $urandom_range(6);
         for (int i = 0; i < n; i++) send_item(KIND_LOAD, SEL_W'($urandom), rand_pos(), rand_pos());
         send_item(KIND_BEGIN, '0, '0, '0);
         n = $urandom_range(8);
         for (int i = 0; i < n; i++) send_item(KIND_TARGET, '0, rand_pos(), rand_pos());
         send_item(KIND_FINISH, '0, '0, '0);
         n = $urandom_range(1, 8);
         for (int i = 0; i < n; i++) begin
            send_item(KIND_TICK, '0, '0, '0);
            send_item(KIND_READ, SEL_W'($urandom), '0, '0);
         end
         // noise: any kind, any fields
         if ($urandom_range(3) == 0)
            send_item(KIND_W'($urandom), SEL_W'($urandom), rand_pos(), rand_pos());
      end
   endtask

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.kind = '0;
      req_bus.particle_sel = '0;
      req_bus.x_pos = '0;
      req_bus.y_pos = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_CENTER_X;
      csr_bus.data = '0;
      rsp_bus.ready = 1'b1;
      mismatches = 0;
      items_sent = 0;
      claims_seen = 0;
      ticks_sent = 0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      idle_cycles = 0;
      for (int i = 0; i < PARTICLES; i++) begin
         active[i] = 0;
         claimed[i] = 0;
      end
      glide_prog = ONE_Q16;
      park_x = '0;
      park_y = '0;
      frames = FRAMES_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_load_all();
      test_directed();
      test_exhaust();
      test_random(25, 0, 0);
      test_random(20, 54, 0);
      test_random(20, 0, 54);
      test_random(20, 23, 23);
      test_random(10, 0, 0);
      wait_drained();
      repeat (600) @(posedge clock);
      mismatches += pending_rsp.size();
      $display("covered %0d requests: %0d claims, %0d ticks, all register settings",
               items_sent, claims_seen, ticks_sent);
      $display("with sender gaps and response stalls in separate and combined phases");
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

FILE: filelist.f
design/gpmg_pkg.sv
design/gpmg_if.sv
design/gpmg_ram.sv
design/gpmg_ctrl.sv
design/gpmg_dp.sv
design/greedy_point_match_glide.sv
sim/greedy_point_match_glide_tb.sv
